### design/stms_pkg.sv
package stms_pkg;

  // item codes
  typedef enum logic [1:0] {
    OP_ROW   = 2'd0,
    OP_LANE  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // statistic groups for a read
  typedef enum logic [1:0] {
    SEL_BUCKET  = 2'd0,
    SEL_ROWPOP  = 2'd1,
    SEL_FEATPOP = 2'd2,
    SEL_COUNTER = 2'd3
  } sel_t;

  // fixed field widths
  localparam int NNZ_W   = 20;
  localparam int BW_W    = 16;
  localparam int SUM_W   = 16;
  localparam int IDX_W   = 6;
  localparam int DMIN_W  = 22;
  localparam int TOTAL_W = 48;
  localparam int HIST_W  = 32;
  localparam int CTR_W   = 32;
  localparam int RVAL_W  = 48;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // counter indexes for a counter read
  localparam logic [IDX_W-1:0] CTR_TOTAL = 6'd0;
  localparam logic [IDX_W-1:0] CTR_MAXROW = 6'd1;
  localparam logic [IDX_W-1:0] CTR_ROWS = 6'd2;
  localparam logic [IDX_W-1:0] CTR_TILES = 6'd3;
  localparam logic [IDX_W-1:0] CTR_DENSE = 6'd4;

  // register file
  localparam logic REG_DENSE_MIN = 1'b0;
  localparam logic [DMIN_W-1:0] DMIN_RESET = 22'd16;

endpackage

### design/sparse_tile_mask_statistics.sv
// Channel | Signals                                   | Beat
// --------+-------------------------------------------+--------------------------------
// apb     | psel penable pwrite paddr pwdata prdata   | write of dense_min_capacity
// in      | in_valid in_ready + 7 item fields         | one row, lane, close or read
// out     | out_valid out_ready + 7 result fields     | one result per input beat
//
// Throughput one item per cycle when out_ready does not stall the output; a result passes from
// input beat into queue, queue into execute stage, then execute into output register.
// Histograms sit in RAMs with one read and one write port; a one-entry bypass per RAM keeps
// back-to-back bumps of the same bin exact.
// Reset is synchronous; histogram bins read zero through valid bits, no clearing pass.
// A 2-entry queue parts front and back; in_ready drops only when it is full, and the
// execute stage holds while the output register waits on out_ready.
module sparse_tile_mask_statistics #(
  parameter int MASK_WIDTH  = 32,
  parameter int ROW_BUCKETS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [stms_pkg::APB_AW-1:0]           paddr,
  input  logic [stms_pkg::APB_DW-1:0]           pwdata,
  output logic [stms_pkg::APB_DW-1:0]           prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            operation,
  input  logic [stms_pkg::NNZ_W-1:0]            row_nnz,
  input  logic [MASK_WIDTH-1:0]                 lane_mask,
  input  logic [MASK_WIDTH-1:0]                 cell_mask,
  input  logic [stms_pkg::BW_W-1:0]             feature_width,
  input  logic [1:0]                            read_select,
  input  logic [stms_pkg::IDX_W-1:0]            read_index,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [$clog2(MASK_WIDTH+1)-1:0]       tile_rows,
  output logic [$clog2(MASK_WIDTH+1)-1:0]       tile_features,
  output logic [stms_pkg::SUM_W-1:0]            tile_nnz,
  output logic [$clog2(MASK_WIDTH*65535+1)-1:0] capacity,
  output logic [$clog2(MASK_WIDTH+1)-1:0]       lane_spread,
  output logic                                  dense_fragment,
  output logic [stms_pkg::RVAL_W-1:0]           read_value
);
  import stms_pkg::*;

  localparam int CNT_W   = $clog2(MASK_WIDTH + 1);
  localparam int BK_W    = $clog2(ROW_BUCKETS);
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    op_t               op;
    logic [NNZ_W-1:0]  row_nnz;
    logic [BK_W-1:0]   bucket;
    logic [CNT_W-1:0]  rows;
    logic [CNT_W-1:0]  feats;
    logic [CNT_W-1:0]  imbalance;
    logic [SUM_W-1:0]  tile_nnz;
    logic [BW_W-1:0]   feature_width;
    sel_t              sel;
    logic [IDX_W-1:0]  idx;
  } entry_t;

  logic [DMIN_W-1:0] dense_min_capacity;
  logic              accept;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  entry_t            front_entry;
  entry_t            q_head;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DENSE_MIN) ? APB_DW'(dense_min_capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dense_min_capacity <= DMIN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DENSE_MIN) begin
      dense_min_capacity <= pwdata[DMIN_W-1:0];
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  stms_front #(
    .MASK_WIDTH(MASK_WIDTH), .ROW_BUCKETS(ROW_BUCKETS), .entry_t(entry_t)
  ) u_front (
    .clk(clk), .rst(rst), .accept(accept),
    .operation(op_t'(operation)), .row_nnz(row_nnz), .lane_mask(lane_mask),
    .cell_mask(cell_mask), .feature_width(feature_width),
    .read_select(sel_t'(read_select)), .read_index(read_index),
    .entry(front_entry)
  );

  stms_queue #(.DEPTH(Q_DEPTH), .entry_t(entry_t)) u_queue (
    .clk(clk), .rst(rst), .push(accept), .push_data(front_entry), .full(q_full),
    .pop(q_pop), .head(q_head), .head_valid(q_valid)
  );

  stms_back #(
    .MASK_WIDTH(MASK_WIDTH), .ROW_BUCKETS(ROW_BUCKETS), .entry_t(entry_t)
  ) u_back (
    .clk(clk), .rst(rst), .dense_min_capacity(dense_min_capacity),
    .head(q_head), .head_valid(q_valid), .pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .tile_rows(tile_rows), .tile_features(tile_features),
    .tile_nnz(tile_nnz), .capacity(capacity), .lane_spread(lane_spread),
    .dense_fragment(dense_fragment), .read_value(read_value)
  );

endmodule

### design/stms_ram.sv
module stms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/stms_front.sv
module stms_front #(
  parameter int  MASK_WIDTH  = 32,
  parameter int  ROW_BUCKETS = 8,
  parameter type entry_t     = logic
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  stms_pkg::op_t                 operation,
  input  logic [stms_pkg::NNZ_W-1:0]    row_nnz,
  input  logic [MASK_WIDTH-1:0]         lane_mask,
  input  logic [MASK_WIDTH-1:0]         cell_mask,
  input  logic [stms_pkg::BW_W-1:0]     feature_width,
  input  stms_pkg::sel_t                read_select,
  input  logic [stms_pkg::IDX_W-1:0]    read_index,
  output entry_t                        entry
);
  import stms_pkg::*;

  localparam int CNT_W  = $clog2(MASK_WIDTH + 1);
  localparam int BK_W   = $clog2(ROW_BUCKETS);
  localparam int BLEN_W = $clog2(NNZ_W + 1);

  // open tile accumulators
  logic [MASK_WIDTH-1:0] union_mask;
  logic [SUM_W-1:0]      tile_nnz_sum;
  logic [CNT_W-1:0]      lane_min;
  logic [CNT_W-1:0]      lane_max;
  logic                  tile_has_entries;

  logic [CNT_W-1:0]  lane_pc;
  logic [CNT_W-1:0]  rows_pc;
  logic [CNT_W-1:0]  feats_pc;
  logic [BLEN_W-1:0] blen;
  logic [BK_W-1:0]   bucket;
  logic [SUM_W:0]    sum_wide;
  logic [CNT_W-1:0]  imbalance;

  // popcounts and row bit length
  always_comb begin
    lane_pc  = '0;
    rows_pc  = '0;
    feats_pc = '0;
    for (int i = 0; i < MASK_WIDTH; i++) begin
      lane_pc  = lane_pc + CNT_W'(lane_mask[i]);
      rows_pc  = rows_pc + CNT_W'(cell_mask[i]);
      feats_pc = feats_pc + CNT_W'(union_mask[i]);
    end
    blen = '0;
    for (int i = 0; i < NNZ_W; i++) begin
      if (row_nnz[i]) begin
        blen = BLEN_W'(i + 1);
      end
    end
  end

  // bucket clamp, saturating lane sum, imbalance
  always_comb begin
    if (int'(blen) > ROW_BUCKETS - 1) begin
      bucket = BK_W'(ROW_BUCKETS - 1);
    end else begin
      bucket = BK_W'(blen);
    end
    sum_wide = {1'b0, tile_nnz_sum} + (SUM_W + 1)'(lane_pc);
    if (tile_has_entries && lane_max >= lane_min) begin
      imbalance = lane_max - lane_min;
    end else begin
      imbalance = '0;
    end
  end

  // queue entry
  always_comb begin
    entry               = '0;
    entry.op            = operation;
    entry.row_nnz       = row_nnz;
    entry.bucket        = bucket;
    entry.rows          = rows_pc;
    entry.feats         = feats_pc;
    entry.imbalance     = imbalance;
    entry.tile_nnz      = tile_nnz_sum;
    entry.feature_width = feature_width;
    entry.sel           = read_select;
    entry.idx           = read_index;
  end

  // tile accumulators follow accepted beats in order
  always_ff @(posedge clk) begin
    if (rst) begin
      union_mask       <= '0;
      tile_nnz_sum     <= '0;
      lane_min         <= CNT_W'(MASK_WIDTH);
      lane_max         <= '0;
      tile_has_entries <= 1'b0;
    end else if (accept) begin
      unique case (operation)
        OP_LANE: begin
          union_mask   <= union_mask | lane_mask;
          tile_nnz_sum <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
          if (lane_pc < lane_min) begin
            lane_min <= lane_pc;
          end
          if (lane_pc > lane_max) begin
            lane_max <= lane_pc;
          end
          tile_has_entries <= 1'b1;
        end
        OP_CLOSE: begin
          union_mask       <= '0;
          tile_nnz_sum     <= '0;
          lane_min         <= CNT_W'(MASK_WIDTH);
          lane_max         <= '0;
          tile_has_entries <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  a_empty_tile_clear: assert property (@(posedge clk) disable iff (rst)
    !tile_has_entries |-> union_mask == '0 && tile_nnz_sum == '0 && lane_max == '0
                          && lane_min == CNT_W'(MASK_WIDTH))
    else $error("empty tile holds stale accumulators");

endmodule

### design/stms_queue.sv
module stms_queue #(
  parameter int  DEPTH   = 2,
  parameter type entry_t = logic
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   head_valid
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH) && !(pop && count == '0))
    else $error("queue count out of range");

endmodule

### design/stms_back.sv
module stms_back #(
  parameter int  MASK_WIDTH  = 32,
  parameter int  ROW_BUCKETS = 8,
  parameter type entry_t     = logic
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic [stms_pkg::DMIN_W-1:0]                   dense_min_capacity,
  input  entry_t                                        head,
  input  logic                                          head_valid,
  output logic                                          pop,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [$clog2(MASK_WIDTH+1)-1:0]               tile_rows,
  output logic [$clog2(MASK_WIDTH+1)-1:0]               tile_features,
  output logic [stms_pkg::SUM_W-1:0]                    tile_nnz,
  output logic [$clog2(MASK_WIDTH*65535+1)-1:0]         capacity,
  output logic [$clog2(MASK_WIDTH+1)-1:0]               lane_spread,
  output logic                                          dense_fragment,
  output logic [stms_pkg::RVAL_W-1:0]                   read_value
);
  import stms_pkg::*;

  localparam int CNT_W  = $clog2(MASK_WIDTH + 1);
  localparam int HDEPTH = MASK_WIDTH + 1;
  localparam int HA_W   = $clog2(HDEPTH);
  localparam int BK_W   = $clog2(ROW_BUCKETS);
  localparam int CAP_W  = $clog2(MASK_WIDTH * ((1 << BW_W) - 1) + 1);
  localparam int PROD_W = CNT_W + BW_W;

  // execute stage
  logic              b_valid;
  entry_t            b_entry;
  logic [CAP_W-1:0]  b_cap;
  logic [BK_W-1:0]   b_addr0;
  logic [HA_W-1:0]   b_addr1;
  logic [HA_W-1:0]   b_addr2;
  logic              rv0, rv1, rv2;
  logic              b_fire;

  // histogram entries written since reset
  logic [ROW_BUCKETS-1:0] hv0;
  logic [HDEPTH-1:0]      hv1;
  logic [HDEPTH-1:0]      hv2;

  // last write to each histogram, covers the read that met it
  logic              f0_valid, f1_valid, f2_valid;
  logic [BK_W-1:0]   f0_addr;
  logic [HA_W-1:0]   f1_addr, f2_addr;
  logic [HIST_W-1:0] f0_data, f1_data, f2_data;

  // counters
  logic [TOTAL_W-1:0] total_row_nonzeros;
  logic [NNZ_W-1:0]   largest_row_nonzeros;
  logic [CTR_W-1:0]   rows_seen;
  logic [CTR_W-1:0]   tiles_seen;
  logic [CTR_W-1:0]   dense_tiles;

  logic [BK_W-1:0]    addr0;
  logic [HA_W-1:0]    addr1, addr2;
  logic [PROD_W-1:0]  prod;
  logic [HIST_W-1:0]  rd0, rd1, rd2;
  logic [HIST_W-1:0]  eff0, eff1, eff2;
  logic [HIST_W-1:0]  inc0, inc1, inc2;
  logic               we0, we12;
  logic               dense;
  logic [TOTAL_W:0]   total_wide;
  logic [RVAL_W-1:0]  rval;

  assign b_fire = b_valid && (!out_valid || out_ready);
  assign pop    = head_valid && (!b_valid || b_fire);

  // read addresses and capacity product from the queue head
  always_comb begin
    if (head.op == OP_READ) begin
      addr0 = BK_W'(head.idx);
      addr1 = HA_W'(head.idx);
      addr2 = HA_W'(head.idx);
    end else begin
      addr0 = head.bucket;
      addr1 = head.rows;
      addr2 = head.feats;
    end
    prod = PROD_W'(head.rows) * PROD_W'(head.feature_width);
  end

  stms_ram #(.WIDTH(HIST_W), .DEPTH(ROW_BUCKETS)) u_bucket_ram (
    .clk(clk), .we(we0), .waddr(b_addr0), .wdata(inc0),
    .re(pop), .raddr(addr0), .rdata(rd0)
  );

  stms_ram #(.WIDTH(HIST_W), .DEPTH(HDEPTH)) u_rowpop_ram (
    .clk(clk), .we(we12), .waddr(b_addr1), .wdata(inc1),
    .re(pop), .raddr(addr1), .rdata(rd1)
  );

  stms_ram #(.WIDTH(HIST_W), .DEPTH(HDEPTH)) u_featpop_ram (
    .clk(clk), .we(we12), .waddr(b_addr2), .wdata(inc2),
    .re(pop), .raddr(addr2), .rdata(rd2)
  );

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pop) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_entry <= head;
      b_cap   <= CAP_W'(prod);
      b_addr0 <= addr0;
      b_addr1 <= addr1;
      b_addr2 <= addr2;
      rv0     <= (int'(addr0) < ROW_BUCKETS) && hv0[addr0];
      rv1     <= (int'(addr1) < HDEPTH) && hv1[addr1];
      rv2     <= (int'(addr2) < HDEPTH) && hv2[addr2];
    end
  end

  // current histogram values and saturating increments
  always_comb begin
    if (f0_valid && f0_addr == b_addr0) begin
      eff0 = f0_data;
    end else begin
      eff0 = rv0 ? rd0 : '0;
    end
    if (f1_valid && f1_addr == b_addr1) begin
      eff1 = f1_data;
    end else begin
      eff1 = rv1 ? rd1 : '0;
    end
    if (f2_valid && f2_addr == b_addr2) begin
      eff2 = f2_data;
    end else begin
      eff2 = rv2 ? rd2 : '0;
    end
    inc0 = (eff0 == '1) ? eff0 : eff0 + 1'b1;
    inc1 = (eff1 == '1) ? eff1 : eff1 + 1'b1;
    inc2 = (eff2 == '1) ? eff2 : eff2 + 1'b1;
    we0  = b_fire && b_entry.op == OP_ROW;
    we12 = b_fire && b_entry.op == OP_CLOSE;
  end

  // dense test and row total
  always_comb begin
    dense = b_cap != '0 && int'(b_cap) >= int'(dense_min_capacity)
            && (int'(b_entry.tile_nnz) * 2) >= int'(b_cap);
    total_wide = {1'b0, total_row_nonzeros} + (TOTAL_W + 1)'(b_entry.row_nnz);
  end

  // read mux
  always_comb begin
    rval = '0;
    unique case (b_entry.sel)
      SEL_BUCKET: begin
        if (int'(b_entry.idx) < ROW_BUCKETS) begin
          rval = RVAL_W'(eff0);
        end
      end
      SEL_ROWPOP: begin
        if (int'(b_entry.idx) <= MASK_WIDTH) begin
          rval = RVAL_W'(eff1);
        end
      end
      SEL_FEATPOP: begin
        if (int'(b_entry.idx) <= MASK_WIDTH) begin
          rval = RVAL_W'(eff2);
        end
      end
      SEL_COUNTER: begin
        unique case (b_entry.idx)
          CTR_TOTAL:  rval = total_row_nonzeros;
          CTR_MAXROW: rval = RVAL_W'(largest_row_nonzeros);
          CTR_ROWS:   rval = RVAL_W'(rows_seen);
          CTR_TILES:  rval = RVAL_W'(tiles_seen);
          CTR_DENSE:  rval = RVAL_W'(dense_tiles);
          default:    rval = '0;
        endcase
      end
      default: rval = '0;
    endcase
  end

  // counters, valid bits and bypass records
  always_ff @(posedge clk) begin
    if (rst) begin
      total_row_nonzeros   <= '0;
      largest_row_nonzeros <= '0;
      rows_seen            <= '0;
      tiles_seen           <= '0;
      dense_tiles          <= '0;
      hv0                  <= '0;
      hv1                  <= '0;
      hv2                  <= '0;
      f0_valid             <= 1'b0;
      f1_valid             <= 1'b0;
      f2_valid             <= 1'b0;
    end else begin
      if (we0) begin
        total_row_nonzeros <= total_wide[TOTAL_W] ? '1 : total_wide[TOTAL_W-1:0];
        if (b_entry.row_nnz > largest_row_nonzeros) begin
          largest_row_nonzeros <= b_entry.row_nnz;
        end
        if (rows_seen != '1) begin
          rows_seen <= rows_seen + 1'b1;
        end
        hv0[b_addr0] <= 1'b1;
        f0_valid     <= 1'b1;
      end
      if (we12) begin
        if (tiles_seen != '1) begin
          tiles_seen <= tiles_seen + 1'b1;
        end
        if (dense && dense_tiles != '1) begin
          dense_tiles <= dense_tiles + 1'b1;
        end
        hv1[b_addr1] <= 1'b1;
        hv2[b_addr2] <= 1'b1;
        f1_valid     <= 1'b1;
        f2_valid     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      f0_addr <= b_addr0;
      f0_data <= inc0;
    end
    if (we12) begin
      f1_addr <= b_addr1;
      f1_data <= inc1;
      f2_addr <= b_addr2;
      f2_data <= inc2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      tile_rows      <= '0;
      tile_features  <= '0;
      tile_nnz       <= '0;
      capacity       <= '0;
      lane_spread    <= '0;
      dense_fragment <= 1'b0;
      read_value     <= '0;
      if (b_entry.op == OP_CLOSE) begin
        tile_rows      <= b_entry.rows;
        tile_features  <= b_entry.feats;
        tile_nnz       <= b_entry.tile_nnz;
        capacity       <= b_cap;
        lane_spread    <= b_entry.imbalance;
        dense_fragment <= dense;
      end
      if (b_entry.op == OP_READ) begin
        read_value <= rval;
      end
    end
  end

  a_dense_ratio: assert property (@(posedge clk) disable iff (rst)
    out_valid && dense_fragment |-> capacity != '0
      && (int'(tile_nnz) * 2) >= int'(capacity))
    else $error("dense flag without half-full capacity");

  a_load_on_fire: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b_fire))
    else $error("result shown without execute");

  a_read_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_value != '0 |-> tile_rows == '0 && capacity == '0
      && !dense_fragment)
    else $error("read result carries tile figures");

endmodule
